[hdl/wra_pkg.sv]
// Shared types and constants for the write range authorization block.
// Used by wra_ctrl, wra_dp and write_range_authorization; no dependencies.
package wra_pkg;

	// Table size default and fixed field widths
	localparam int MAX_RANGES_DEF = 64;
	localparam int CFG_W          = 33;
	localparam int CFG_IDX_W      = 2;
	localparam int ADDR_W         = 32;
	localparam int END_W          = 33;
	localparam int SLOT_W         = 6;
	localparam int RCOUNT_W       = 7;

	// Reset value of the capacity configuration register
	localparam logic [CFG_W-1:0] CAPACITY_RESET = 33'd33554432;

	// Protected regions, half-open [lo, hi)
	localparam logic [END_W-1:0] PROT1A_LO = 33'h0000000;
	localparam logic [END_W-1:0] PROT1A_HI = 33'h0010000;
	localparam logic [END_W-1:0] PROT1B_LO = 33'h0040000;
	localparam logic [END_W-1:0] PROT1B_HI = 33'h0060000;
	localparam logic [END_W-1:0] PROT2_LO  = 33'h07F0000;
	localparam logic [END_W-1:0] PROT2_HI  = 33'h0810000;

	// Protection mode codes
	localparam logic [1:0] PMODE_NONE = 2'd0;
	localparam logic [1:0] PMODE_LOW  = 2'd1;
	localparam logic [1:0] PMODE_HIGH = 2'd2;

	// Operation codes
	localparam logic OP_CHECK = 1'b0;
	localparam logic OP_LOAD  = 1'b1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STRICT   = 2'd0,
		REG_PROTECT  = 2'd1,
		REG_CAPACITY = 2'd2,
		REG_RCOUNT   = 2'd3
	} reg_idx_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;      // latch request fields, write table on a load
		logic sweep_start;  // begin one pass over the range table
		logic advance;      // move cursor to furthest reach found
		logic finish;       // post a result next cycle
		logic result;       // value of allowed for that result
	} wra_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic pre_ok;       // nonzero length, inside capacity, clear of protection
		logic strict;       // strict mode register
		logic n_zero;       // no usable table entries
		logic sweep_done;   // last entry of the pass evaluated this cycle
		logic stuck;        // pass found no further reach
		logic reach;        // furthest reach covers the span end
	} wra_sts_t;

endpackage

[hdl/wra_ctrl.sv]
// Sequencing state machine for the write range authorization block.
// Depends on wra_pkg for command and status structs.
module wra_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              operation,
	input  wra_pkg::wra_sts_t sts,
	output wra_pkg::wra_cmd_t cmd,
	output logic              busy
);
	import wra_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_SWEEP = 4'b0100,
		ST_STEP  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					if (operation == OP_LOAD) begin
						// load acknowledged with allowed low
						cmd.finish = 1'b1;
						cmd.result = 1'b0;
					end else begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (!sts.pre_ok) begin
					cmd.finish = 1'b1;
					cmd.result = 1'b0;
					state_d    = ST_IDLE;
				end else if (!sts.strict) begin
					cmd.finish = 1'b1;
					cmd.result = 1'b1;
					state_d    = ST_IDLE;
				end else if (sts.n_zero) begin
					cmd.finish = 1'b1;
					cmd.result = 1'b0;
					state_d    = ST_IDLE;
				end else begin
					cmd.sweep_start = 1'b1;
					state_d         = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (sts.sweep_done) begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				if (sts.stuck) begin
					cmd.finish = 1'b1;
					cmd.result = 1'b0;
					state_d    = ST_IDLE;
				end else if (sts.reach) begin
					cmd.finish = 1'b1;
					cmd.result = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					cmd.advance     = 1'b1;
					cmd.sweep_start = 1'b1;
					state_d         = ST_SWEEP;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

[hdl/wra_dp.sv]
// Datapath: configuration registers, range table memory, span checks and cursor.
// Depends on wra_pkg; driven by wra_ctrl commands.
module wra_dp #(
	parameter int MAX_RANGES = wra_pkg::MAX_RANGES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [wra_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wra_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        operation,
	input  logic [wra_pkg::ADDR_W-1:0]  offset,
	input  logic [wra_pkg::ADDR_W-1:0]  length,
	input  logic [wra_pkg::SLOT_W-1:0]  entry_index,
	input  wra_pkg::wra_cmd_t           cmd,
	output wra_pkg::wra_sts_t           sts,
	output logic                        done,
	output logic                        allowed
);
	import wra_pkg::*;

	localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int CNT_W = $clog2(MAX_RANGES + 1);

	// Configuration registers
	logic                strict_q;
	logic [1:0]          protect_q;
	logic [CFG_W-1:0]    capacity_q;
	logic [RCOUNT_W-1:0] rcount_q;

	// Span and cursor
	logic [ADDR_W-1:0] s_q;
	logic [END_W-1:0]  e_q;
	logic [END_W-1:0]  cur_q;
	logic [END_W-1:0]  best_q;

	// Table sweep
	logic [2*ADDR_W-1:0] mem [MAX_RANGES];
	logic [CNT_W-1:0]    rd_idx_q;
	logic                issuing_q;
	logic                rvalid_s1;
	logic                last_s1;
	logic [2*ADDR_W-1:0] rdata_s1;

	logic                done_q;
	logic                allowed_q;

	logic [CNT_W-1:0]    n_use;
	logic [CNT_W-1:0]    n_last;
	logic                slot_ok;
	logic                mem_we;
	logic [IDX_W-1:0]    wr_addr;
	logic [IDX_W-1:0]    rd_addr;
	logic [END_W-1:0]    ent_start;
	logic [END_W-1:0]    ent_end;
	logic [END_W-1:0]    s_ext;
	logic                forbidden;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q   <= 1'b1;
			protect_q  <= PMODE_NONE;
			capacity_q <= CAPACITY_RESET;
			rcount_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STRICT:   strict_q   <= cfg_data[0];
				REG_PROTECT:  protect_q  <= cfg_data[1:0];
				REG_CAPACITY: capacity_q <= cfg_data;
				REG_RCOUNT:   rcount_q   <= cfg_data[RCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Usable entry count, clamped to table depth
	assign n_use  = (32'(rcount_q) > 32'(MAX_RANGES)) ? CNT_W'(MAX_RANGES)
	                                                 : CNT_W'(rcount_q);
	assign n_last = n_use - CNT_W'(1);

	// Table write on a load to an existing slot
	assign slot_ok = (32'(entry_index) < 32'(MAX_RANGES));
	assign mem_we  = cmd.capture && (operation == OP_LOAD) && slot_ok;
	assign wr_addr = IDX_W'(entry_index);
	assign rd_addr = rd_idx_q[IDX_W-1:0];

	// Range table memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= {offset, length};
		end
		if (issuing_q) begin
			rdata_s1 <= mem[rd_addr];
			last_s1  <= (rd_idx_q == n_last);
		end
	end

	// Sweep address sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q <= 1'b0;
			rvalid_s1 <= 1'b0;
		end else begin
			rvalid_s1 <= issuing_q;
			if (cmd.sweep_start) begin
				issuing_q <= 1'b1;
			end else if (issuing_q && (rd_idx_q == n_last)) begin
				issuing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep_start) begin
			rd_idx_q <= '0;
		end else if (issuing_q) begin
			rd_idx_q <= rd_idx_q + CNT_W'(1);
		end
	end

	// Entry bounds, 33 bits so ends never wrap
	assign ent_start = {1'b0, rdata_s1[2*ADDR_W-1:ADDR_W]};
	assign ent_end   = ent_start + {1'b0, rdata_s1[ADDR_W-1:0]};

	// Span capture, cursor and furthest reach
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			s_q    <= offset;
			e_q    <= {1'b0, offset} + {1'b0, length};
			cur_q  <= {1'b0, offset};
			best_q <= {1'b0, offset};
		end else begin
			if (cmd.advance) begin
				cur_q <= best_q;
			end
			if (rvalid_s1 && (ent_start <= cur_q) && (ent_end > best_q)) begin
				best_q <= ent_end;
			end
		end
	end

	// Capacity and protected region test
	assign s_ext = {1'b0, s_q};
	always_comb begin
		forbidden = (e_q > capacity_q);
		case (protect_q)
			PMODE_LOW: begin
				if ((s_ext < PROT1A_HI) && (PROT1A_LO < e_q)) forbidden = 1'b1;
				if ((s_ext < PROT1B_HI) && (PROT1B_LO < e_q)) forbidden = 1'b1;
			end
			PMODE_HIGH: begin
				if ((s_ext < PROT2_HI) && (PROT2_LO < e_q)) forbidden = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		sts.pre_ok     = (e_q != s_ext) && !forbidden;
		sts.strict     = strict_q;
		sts.n_zero     = (n_use == '0);
		sts.sweep_done = rvalid_s1 && last_s1;
		sts.stuck      = (best_q == cur_q);
		sts.reach      = (best_q >= e_q);
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q    <= 1'b0;
			allowed_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.finish) begin
				allowed_q <= cmd.result;
			end
		end
	end

	assign done    = done_q;
	assign allowed = allowed_q;

endmodule

[hdl/write_range_authorization.sv]
// Top level of the write range authorization block.
// Depends on wra_pkg, wra_ctrl and wra_dp.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low.
//   operation selects a load of one allowed range (offset, length) into
//   table slot entry_index, or a check of the span [offset, offset+length).
//   Every request yields one result: done is high for exactly one cycle
//   with allowed valid; loads always return allowed low. The receiver
//   cannot hold results off, so done is a single-cycle strobe.
//   Configuration: cfg_we, cfg_index, cfg_data write strict_mode,
//   protect_mode, store capacity and range_count; write only while idle.
// Sequencing (from accept to done):
//   a load posts done straight from idle; a check passes the CHECK state,
//   which posts done on an early refusal or with strict mode off. A strict
//   check then takes k cursor steps, at most n+1, n = range count clamped to
//   the table depth. Each step is one pass over the table through its single registered read port.
// One request is in flight at a time; a new request may be taken in the
//   cycle its predecessor's done is shown.
// Reset: clears control state and restores register defaults; the range
//   table is not cleared and must be loaded before use.
module write_range_authorization #(
	parameter int MAX_RANGES = wra_pkg::MAX_RANGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          operation,
	input  logic [wra_pkg::ADDR_W-1:0]    offset,
	input  logic [wra_pkg::ADDR_W-1:0]    length,
	input  logic [wra_pkg::SLOT_W-1:0]    entry_index,
	output logic                          done,
	output logic                          allowed,
	input  logic                          cfg_we,
	input  logic [wra_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wra_pkg::CFG_W-1:0]     cfg_data
);
	import wra_pkg::*;

	wra_cmd_t cmd;
	wra_sts_t sts;

	// Sequencer
	wra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	// Datapath
	wra_dp #(
		.MAX_RANGES (MAX_RANGES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.operation   (operation),
		.offset      (offset),
		.length      (length),
		.entry_index (entry_index),
		.cmd         (cmd),
		.sts         (sts),
		.done        (done),
		.allowed     (allowed)
	);

`ifndef SYNTHESIS
	// Results only appear once the sequencer has returned to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result posted while busy");

	// A load is acknowledged on the next cycle with allowed low
	a_load_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (operation == OP_LOAD)) |=> (done && !allowed))
		else $error("load not acknowledged");

	// A zero-length check is refused from the CHECK state with allowed low
	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (operation == OP_CHECK) && (length == '0))
			|-> ##2 (done && !allowed))
		else $error("zero-length span not refused");
`endif

endmodule
